@@ design/udp_port_listener_table_core_macros.svh @@
// assertion macros for the udp port listener table
`ifndef UDP_PORT_LISTENER_TABLE_CORE_MACROS_SVH
`define UDP_PORT_LISTENER_TABLE_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define UPLT_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define UPLT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/uplt_pkg.sv @@
// shared types, codes and helpers for the udp port listener table
package uplt_pkg;

    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [1:0] CMD_DELIVER    = 2'd2;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;

    localparam logic [15:0] HDR_BYTES = 16'd8;
    localparam logic [4:0]  RM_MAX    = 5'd31;

    // table address field wide enough for the largest supported table (64)
    localparam int TBL_ADDR_W = 6;

    typedef enum logic [2:0] {
        ST_ADDED       = 3'd0,
        ST_UPDATED     = 3'd1,
        ST_FULL        = 3'd2,
        ST_REMOVED     = 3'd3,
        ST_DELIVERED   = 3'd4,
        ST_NO_LISTENER = 3'd5,
        ST_TOO_SHORT   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        TBL_NOP,
        TBL_NEW,
        TBL_HND,
        TBL_CLEAR
    } tbl_op_t;

    typedef struct packed {
        tbl_op_t                 op;
        logic [TBL_ADDR_W-1:0]   addr;
        logic [15:0]             port;
        logic [7:0]              handler;
    } tbl_ctrl_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] port;
        logic [7:0]  handler_id;
        logic [15:0] header_dst_raw;
        logic [15:0] header_src_raw;
        logic [15:0] udp_length;
        logic [31:0] source_ip;
    } cmd_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  target_handler;
        logic [15:0] sender_port;
        logic [31:0] sender_ip;
        logic [15:0] payload_bytes;
        logic [4:0]  removed_count;
    } res_item_t;

    function automatic logic [15:0] swap16(input logic [15:0] x);
        swap16 = {x[7:0], x[15:8]};
    endfunction

endpackage

@@ design/uplt_ifs.sv @@
// valid/ready channel interfaces for commands and results
interface uplt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] port;
    logic [7:0]  handler_id;
    logic [15:0] header_dst_raw;
    logic [15:0] header_src_raw;
    logic [15:0] udp_length;
    logic [31:0] source_ip;

    modport source (
        output valid, command, port, handler_id, header_dst_raw, header_src_raw,
               udp_length, source_ip,
        input  ready
    );
    modport sink (
        input  valid, command, port, handler_id, header_dst_raw, header_src_raw,
               udp_length, source_ip,
        output ready
    );
endinterface

interface uplt_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  target_handler;
    logic [15:0] sender_port;
    logic [31:0] sender_ip;
    logic [15:0] payload_bytes;
    logic [4:0]  removed_count;

    modport source (
        output valid, status, target_handler, sender_port, sender_ip, payload_bytes,
               removed_count,
        input  ready
    );
    modport sink (
        input  valid, status, target_handler, sender_port, sender_ip, payload_bytes,
               removed_count,
        output ready
    );
endinterface

@@ design/uplt_entry_table.sv @@
// listener entry store: valid flags in flops, port and handler words in memory
module uplt_entry_table
    import uplt_pkg::*;
#(
    parameter int ENTRIES = 16,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tbl_ctrl_t          ctrl,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [15:0]        rd_port,
    output logic [7:0]         rd_handler,
    output logic [ENTRIES-1:0] entry_valid
);

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [15:0]        port_mem [ENTRIES];
    logic [7:0]         hnd_mem  [ENTRIES];
    logic [15:0]        rd_port_reg;
    logic [7:0]         rd_hnd_reg;
    logic [IDX_W-1:0]   waddr;

    assign waddr = ctrl.addr[IDX_W-1:0];

    always_comb
    begin
        valid_next = valid_reg;
        unique case (ctrl.op)
            TBL_NEW:   valid_next[waddr] = 1'b1;
            TBL_CLEAR: valid_next[waddr] = 1'b0;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == TBL_NEW)
        begin
            port_mem[waddr] <= ctrl.port;
        end
        if (ctrl.op == TBL_NEW || ctrl.op == TBL_HND)
        begin
            hnd_mem[waddr] <= ctrl.handler;
        end
        rd_port_reg <= port_mem[rd_addr];
        rd_hnd_reg  <= hnd_mem[rd_addr];
    end

    assign rd_port     = rd_port_reg;
    assign rd_handler  = rd_hnd_reg;
    assign entry_valid = valid_reg;

endmodule

@@ design/uplt_scan_seq.sv @@
// command sequencer: one shared port comparator walks the table an entry a cycle
module uplt_scan_seq
    import uplt_pkg::*;
#(
    parameter int ENTRIES = 16,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W = $clog2(ENTRIES + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_item_t          cmd_item,
    output logic               res_valid,
    input  logic               res_ready,
    output res_item_t          res_item,
    output tbl_ctrl_t          tbl_ctrl,
    output logic [IDX_W-1:0]   rd_addr,
    input  logic [15:0]        rd_port,
    input  logic [7:0]         rd_handler,
    input  logic [ENTRIES-1:0] entry_valid
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        FINISH
    } state_t;

    state_t           state_reg,   state_next;
    logic [1:0]       cmd_reg,     cmd_next;
    logic             short_reg,   short_next;
    logic [15:0]      key_reg,     key_next;
    logic [7:0]       hid_reg,     hid_next;
    logic [15:0]      sport_reg,   sport_next;
    logic [31:0]      sip_reg,     sip_next;
    logic [15:0]      pay_reg,     pay_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             hit_reg,     hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [7:0]       hit_hnd_reg, hit_hnd_next;
    logic             free_reg,    free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [4:0]       rm_cnt_reg,  rm_cnt_next;
    res_item_t        res_reg,     res_next;
    logic             res_valid_reg, res_valid_next;
    logic             entry_match;
    logic             entry_free;

    // compare stage sees the word read for cmp_idx_reg in the previous cycle
    assign entry_match = cmp_vld_reg && entry_valid[cmp_idx_reg] && (rd_port == key_reg);
    assign entry_free  = cmp_vld_reg && !entry_valid[cmp_idx_reg];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        short_next     = short_reg;
        key_next       = key_reg;
        hid_next       = hid_reg;
        sport_next     = sport_reg;
        sip_next       = sip_reg;
        pay_next       = pay_reg;
        cnt_next       = cnt_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_hnd_next   = hit_hnd_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        rm_cnt_next    = rm_cnt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        rd_addr        = cnt_reg[IDX_W-1:0];
        tbl_ctrl.op      = TBL_NOP;
        tbl_ctrl.addr    = '0;
        tbl_ctrl.port    = key_reg;
        tbl_ctrl.handler = hid_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next      = cmd_item.command;
                    key_next      = (cmd_item.command == CMD_DELIVER) ?
                                    swap16(cmd_item.header_dst_raw) : cmd_item.port;
                    hid_next      = cmd_item.handler_id;
                    sport_next    = swap16(cmd_item.header_src_raw);
                    sip_next      = cmd_item.source_ip;
                    pay_next      = cmd_item.udp_length - HDR_BYTES;
                    short_next    = cmd_item.udp_length < HDR_BYTES;
                    cnt_next      = '0;
                    cmp_vld_next  = 1'b0;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    rm_cnt_next   = '0;
                    priority if (cmd_item.command == CMD_UNUSED)
                    begin
                        state_next = IDLE;
                    end
                    else if (cmd_item.command == CMD_DELIVER &&
                             cmd_item.udp_length < HDR_BYTES)
                    begin
                        state_next = FINISH;
                    end
                    else
                    begin
                        state_next = SCAN;
                    end
                end
            end

            SCAN:
            begin
                if (cnt_reg == CNT_W'(ENTRIES))
                begin
                    cmp_vld_next = 1'b0;
                    state_next   = FINISH;
                end
                else
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next     = cnt_reg + CNT_W'(1);
                end

                if (entry_match && !hit_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    hit_hnd_next = rd_handler;
                end
                if (entry_free && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = cmp_idx_reg;
                end
                if (entry_match && cmd_reg == CMD_UNREGISTER)
                begin
                    tbl_ctrl.op   = TBL_CLEAR;
                    tbl_ctrl.addr = TBL_ADDR_W'(cmp_idx_reg);
                    if (rm_cnt_reg != RM_MAX)
                    begin
                        rm_cnt_next = rm_cnt_reg + 5'd1;
                    end
                end
            end

            FINISH:
            begin
                // wait for a free result slot, then commit the table write once
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next          = 1'b1;
                    state_next              = IDLE;
                    res_next.status         = ST_FULL;
                    res_next.target_handler = '0;
                    res_next.sender_port    = '0;
                    res_next.sender_ip      = '0;
                    res_next.payload_bytes  = '0;
                    res_next.removed_count  = '0;
                    unique case (cmd_reg)
                        CMD_REGISTER:
                        begin
                            priority if (hit_reg)
                            begin
                                res_next.status = ST_UPDATED;
                                tbl_ctrl.op     = TBL_HND;
                                tbl_ctrl.addr   = TBL_ADDR_W'(hit_idx_reg);
                            end
                            else if (free_reg)
                            begin
                                res_next.status = ST_ADDED;
                                tbl_ctrl.op     = TBL_NEW;
                                tbl_ctrl.addr   = TBL_ADDR_W'(free_idx_reg);
                            end
                            else
                            begin
                                res_next.status = ST_FULL;
                            end
                        end
                        CMD_UNREGISTER:
                        begin
                            res_next.status        = ST_REMOVED;
                            res_next.removed_count = rm_cnt_reg;
                        end
                        default:
                        begin
                            if (short_reg)
                            begin
                                res_next.status = ST_TOO_SHORT;
                            end
                            else
                            begin
                                res_next.status         = hit_reg ? ST_DELIVERED
                                                                  : ST_NO_LISTENER;
                                res_next.target_handler = hit_reg ? hit_hnd_reg : 8'd0;
                                res_next.sender_port    = sport_reg;
                                res_next.sender_ip      = sip_reg;
                                res_next.payload_bytes  = pay_reg;
                            end
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cmd_reg       <= CMD_REGISTER;
            short_reg     <= 1'b0;
            key_reg       <= '0;
            hid_reg       <= '0;
            sport_reg     <= '0;
            sip_reg       <= '0;
            pay_reg       <= '0;
            cnt_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            hit_hnd_reg   <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            rm_cnt_reg    <= '0;
            res_reg       <= '{status: ST_ADDED, default: '0};
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            short_reg     <= short_next;
            key_reg       <= key_next;
            hid_reg       <= hid_next;
            sport_reg     <= sport_next;
            sip_reg       <= sip_next;
            pay_reg       <= pay_next;
            cnt_reg       <= cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_idx_reg   <= cmp_idx_next;
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            hit_hnd_reg   <= hit_hnd_next;
            free_reg      <= free_next;
            free_idx_reg  <= free_idx_next;
            rm_cnt_reg    <= rm_cnt_next;
            res_reg       <= res_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign cmd_ready = (state_reg == IDLE);
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

endmodule

@@ design/udp_port_listener_table_core.sv @@
// udp port listener table, top level
// register, unregister and deliver scan all ENTRIES slots, one per cycle through one
// port comparator, then the FINISH state issues the registered result once the result
// slot is free; a new item is taken only after the last one's result is issued, and a too-short packet skips the scan
// async active-low reset clears all active flags and the sequencer; ready out of reset
module udp_port_listener_table_core
    import uplt_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input logic        clk,
    input logic        rst_n,
    uplt_cmd_if.sink   cmd,
    uplt_res_if.source res
);

    `include "udp_port_listener_table_core_macros.svh"

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    cmd_item_t          cmd_item;
    res_item_t          res_item;
    tbl_ctrl_t          tbl_ctrl;
    logic [IDX_W-1:0]   rd_addr;
    logic [15:0]        rd_port;
    logic [7:0]         rd_handler;
    logic [ENTRIES-1:0] entry_valid;
    logic               res_valid;
    logic               cmd_ready;

    assign cmd_item.command        = cmd.command;
    assign cmd_item.port           = cmd.port;
    assign cmd_item.handler_id     = cmd.handler_id;
    assign cmd_item.header_dst_raw = cmd.header_dst_raw;
    assign cmd_item.header_src_raw = cmd.header_src_raw;
    assign cmd_item.udp_length     = cmd.udp_length;
    assign cmd_item.source_ip      = cmd.source_ip;

    uplt_entry_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (tbl_ctrl),
        .rd_addr     (rd_addr),
        .rd_port     (rd_port),
        .rd_handler  (rd_handler),
        .entry_valid (entry_valid)
    );

    uplt_scan_seq #(
        .ENTRIES (ENTRIES)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd.valid),
        .cmd_ready   (cmd_ready),
        .cmd_item    (cmd_item),
        .res_valid   (res_valid),
        .res_ready   (res.ready),
        .res_item    (res_item),
        .tbl_ctrl    (tbl_ctrl),
        .rd_addr     (rd_addr),
        .rd_port     (rd_port),
        .rd_handler  (rd_handler),
        .entry_valid (entry_valid)
    );

    assign cmd.ready          = cmd_ready;
    assign res.valid          = res_valid;
    assign res.status         = res_item.status;
    assign res.target_handler = res_item.target_handler;
    assign res.sender_port    = res_item.sender_port;
    assign res.sender_ip      = res_item.sender_ip;
    assign res.payload_bytes  = res_item.payload_bytes;
    assign res.removed_count  = res_item.removed_count;

    // a real command keeps the block busy for at least the next cycle
    `UPLT_ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, cmd.valid && cmd_ready && cmd.command != CMD_UNUSED, !cmd_ready, "ready held after a command was taken")

    // a new listener only lands in a free slot
    `UPLT_ASSERT_NOW(a_new_into_free, clk, rst_n, tbl_ctrl.op == TBL_NEW, !entry_valid[tbl_ctrl.addr[IDX_W-1:0]], "new entry written over an active slot")

    // unregister only clears active slots
    `UPLT_ASSERT_NOW(a_clear_active, clk, rst_n, tbl_ctrl.op == TBL_CLEAR, entry_valid[tbl_ctrl.addr[IDX_W-1:0]], "clear issued on an inactive slot")

    // a register write always goes with a result in the next cycle
    `UPLT_ASSERT_NEXT(a_write_has_result, clk, rst_n, tbl_ctrl.op == TBL_NEW || tbl_ctrl.op == TBL_HND, res_valid, "register write without a result")

endmodule
